@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the biquad filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define BQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define BQ_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/bqdf1_pkg.sv @@
// ---------------------------------------------------------------------------
// Biquad filter package
// Types and fixed constants shared by the direct form I biquad modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bqdf1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned SampleW = 24;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned YW      = 40;
  localparam int unsigned ChW     = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [YW-1:0] YMax = {1'b0, {(YW-1){1'b1}}};
  localparam logic signed [YW-1:0] YMin = {1'b1, {(YW-1){1'b0}}};

  localparam logic signed [YW:0] RndPos = (YW+1)'(256);
  localparam logic signed [YW:0] RndNeg = (YW+1)'(255);

  localparam logic signed [CoefW-1:0] CoefB0Reset = 32'sh2000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_B0 = 3'd0,
    CFG_B1 = 3'd1,
    CFG_B2 = 3'd2,
    CFG_A1 = 3'd3,
    CFG_A2 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic signed [SampleW-1:0] x1;
    logic signed [SampleW-1:0] x2;
    logic signed [YW-1:0]      y1;
    logic signed [YW-1:0]      y2;
  } hist_t;

endpackage

`default_nettype wire

@@ rtl/bqdf1_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bqdf1_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/bqdf1_hist.sv @@
// ---------------------------------------------------------------------------
// Channel history store
// Per-channel delay lines in RAM, with valid bits that stand for the reset
// value and a bypass for a read that meets a write to the same channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bqdf1_hist #(
  parameter int unsigned NumChannels = 8,
  localparam int unsigned AddrW = (NumChannels > 1) ? $clog2(NumChannels) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rd_en_i,
  input  wire logic [AddrW-1:0]   rd_addr_i,
  input  wire logic               wr_en_i,
  input  wire logic [AddrW-1:0]   wr_addr_i,
  input  bqdf1_pkg::hist_t        wr_data_i,
  output bqdf1_pkg::hist_t        rd_data_o
);

  localparam int unsigned HistW = $bits(bqdf1_pkg::hist_t);

  logic [NumChannels-1:0] vld_q;
  logic                   vld_hit_q;
  logic                   byp_hit_q;
  bqdf1_pkg::hist_t       byp_data_q;
  logic [HistW-1:0]       ram_rdata;

  bqdf1_ram #(
    .Width (HistW),
    .Depth (NumChannels)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_hit_q <= 1'b0;
      byp_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_hit_q <= vld_q[rd_addr_i];
        byp_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      byp_data_q <= wr_data_i;
    end
  end

  always_comb begin
    if (byp_hit_q) begin
      rd_data_o = byp_data_q;
    end else if (vld_hit_q) begin
      rd_data_o = bqdf1_pkg::hist_t'(ram_rdata);
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bqdf1_core.sv @@
// ---------------------------------------------------------------------------
// Biquad arithmetic
// Five products, the Q.52 sum, saturation to the 40-bit output history and
// rounding of the result to a 24-bit sample.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bqdf1_core (
  input  bqdf1_pkg::coef_t                              coef_i,
  input  wire logic signed [bqdf1_pkg::SampleW-1:0]     x_i,
  input  bqdf1_pkg::hist_t                              hist_i,
  output logic signed [bqdf1_pkg::YW-1:0]               y_o,
  output logic [bqdf1_pkg::WordW-1:0]                   word_o
);

  logic signed [55:0] p_b0;
  logic signed [55:0] p_b1;
  logic signed [55:0] p_b2;
  logic signed [51:0] p_a1_hi;
  logic signed [51:0] p_a2_hi;
  logic signed [52:0] p_a1_lo;
  logic signed [52:0] p_a2_lo;
  logic signed [63:0] fb1;
  logic signed [63:0] fb2;
  logic signed [63:0] acc;
  logic signed [43:0] y_wide;
  logic signed [bqdf1_pkg::YW:0] rnd;

  // Each feedback product splits y into a signed upper and an unsigned lower
  // half so that no multiplier exceeds 32 by 21 bits.
  assign p_b0    = $signed(coef_i.b0) * $signed(x_i);
  assign p_b1    = $signed(coef_i.b1) * $signed(hist_i.x1);
  assign p_b2    = $signed(coef_i.b2) * $signed(hist_i.x2);
  assign p_a1_hi = $signed(coef_i.a1) * $signed(hist_i.y1[39:20]);
  assign p_a2_hi = $signed(coef_i.a2) * $signed(hist_i.y2[39:20]);
  assign p_a1_lo = $signed(coef_i.a1) * $signed({1'b0, hist_i.y1[19:0]});
  assign p_a2_lo = $signed(coef_i.a2) * $signed({1'b0, hist_i.y2[19:0]});

  assign fb1 = (64'(p_a1_hi) <<< 11) + 64'(p_a1_lo >>> 9);
  assign fb2 = (64'(p_a2_hi) <<< 11) + 64'(p_a2_lo >>> 9);

  assign acc = 64'(p_b0) + 64'(p_b1) + 64'(p_b2) - fb1 - fb2;

  assign y_wide = acc[63:20];

  always_comb begin
    if (y_wide[43:39] != {5{y_wide[39]}}) begin
      y_o = y_wide[43] ? bqdf1_pkg::YMin : bqdf1_pkg::YMax;
    end else begin
      y_o = y_wide[39:0];
    end
  end

  // Rounding half away from zero: a negative value takes one less before the
  // floor shift.
  assign rnd    = {y_o[39], y_o} + (y_o[39] ? bqdf1_pkg::RndNeg : bqdf1_pkg::RndPos);
  assign word_o = {rnd[32:9], 8'h00};

endmodule

`default_nettype wire

@@ rtl/biquad_df1_multichannel_filter.sv @@
// ---------------------------------------------------------------------------
// Multichannel direct form I biquad filter
// One shared coefficient set, a delay history per channel, one word in and
// one word out per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_ready_o   sample_word_i, channel_i
// output    out        out_valid_o/out_ready_i out_word_o, out_channel_o
// config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A word enters the input register with its channel history read from RAM,
// and its result passes combinationally through the seven multipliers and
// the sum into the output register as the input register moves on. Reset
// clears the history valid bits, so every channel starts from zero with no
// clearing pass. A stalled output holds the input register, and a new word
// is taken whenever the input register is empty or moves on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module biquad_df1_multichannel_filter #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [bqdf1_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  wire logic [bqdf1_pkg::CoefW-1:0]            cfg_wdata_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic signed [bqdf1_pkg::WordW-1:0]     sample_word_i,
  input  wire logic [bqdf1_pkg::ChW-1:0]              channel_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed [bqdf1_pkg::WordW-1:0]          out_word_o,
  output logic [bqdf1_pkg::ChW-1:0]                   out_channel_o
);

  localparam int unsigned AddrW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  bqdf1_pkg::coef_t coef_q;

  logic                                s1_valid_q;
  logic                                s1_in_range_q;
  logic signed [bqdf1_pkg::SampleW-1:0] s1_x_q;
  logic [bqdf1_pkg::ChW-1:0]           s1_ch_q;
  logic [AddrW-1:0]                    s1_addr_q;

  logic                                out_valid_q;
  logic [bqdf1_pkg::WordW-1:0]         out_word_q;
  logic [bqdf1_pkg::ChW-1:0]           out_ch_q;

  logic                                in_accept;
  logic                                s1_advance;
  logic                                in_range;
  logic [AddrW+bqdf1_pkg::ChW-1:0]     ch_ext;
  logic [AddrW-1:0]                    in_addr;
  bqdf1_pkg::hist_t                    hist_rd;
  bqdf1_pkg::hist_t                    hist_wr;
  logic signed [bqdf1_pkg::YW-1:0]     y;
  logic [bqdf1_pkg::WordW-1:0]         core_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= bqdf1_pkg::CoefB0Reset;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else if (cfg_we_i) begin
      case (bqdf1_pkg::cfg_idx_e'(cfg_idx_i))
        bqdf1_pkg::CFG_B0: begin
          coef_q.b0 <= cfg_wdata_i;
        end
        bqdf1_pkg::CFG_B1: begin
          coef_q.b1 <= cfg_wdata_i;
        end
        bqdf1_pkg::CFG_B2: begin
          coef_q.b2 <= cfg_wdata_i;
        end
        bqdf1_pkg::CFG_A1: begin
          coef_q.a1 <= cfg_wdata_i;
        end
        bqdf1_pkg::CFG_A2: begin
          coef_q.a2 <= cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_accept  = in_valid_i && in_ready_o;

  assign in_range = 32'(channel_i) < NUM_CHANNELS;
  assign ch_ext   = {{AddrW{1'b0}}, channel_i};
  assign in_addr  = ch_ext[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_in_range_q <= in_range;
      s1_x_q        <= sample_word_i[31:8];
      s1_ch_q       <= channel_i;
      s1_addr_q     <= in_addr;
    end
    if (s1_advance) begin
      out_word_q <= s1_in_range_q ? core_word : '0;
      out_ch_q   <= s1_ch_q;
    end
  end

  assign hist_wr.x1 = s1_x_q;
  assign hist_wr.x2 = hist_rd.x1;
  assign hist_wr.y1 = y;
  assign hist_wr.y2 = hist_rd.y1;

  bqdf1_hist #(
    .NumChannels (NUM_CHANNELS)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept && in_range),
    .rd_addr_i (in_addr),
    .wr_en_i   (s1_advance && s1_in_range_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (hist_wr),
    .rd_data_o (hist_rd)
  );

  bqdf1_core u_core (
    .coef_i (coef_q),
    .x_i    (s1_x_q),
    .hist_i (hist_rd),
    .y_o    (y),
    .word_o (core_word)
  );

  assign out_valid_o   = out_valid_q;
  assign out_word_o    = out_word_q;
  assign out_channel_o = out_ch_q;

  `BQ_ASSERT(a_accept_fills_s1, clk_i, rst_ni, in_accept |=> s1_valid_q, "accepted word lost")
  `BQ_ASSERT(a_out_from_s1, clk_i, rst_ni, $rose(out_valid_o) |-> $past(s1_valid_q), "result without a word")
  `BQ_ASSERT(a_low_bits_zero, clk_i, rst_ni, out_valid_o |-> (out_word_o[7:0] == 8'h00), "low bits set")
  `BQ_ASSERT(a_bad_ch_zero, clk_i, rst_ni, (out_valid_o && (32'(out_channel_o) >= NUM_CHANNELS)) |-> (out_word_o == '0), "bad channel not zero")

endmodule

`default_nettype wire

@@ tb/biquad_df1_multichannel_filter_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multichannel direct form I biquad filter testbench
// Streams audio words over all eight channels under a series of coefficient
// sets. The sets include unity gain, half gain for the rounding ties, stable
// low-pass sections, fully random sets and the register extremes that drive
// the output history into saturation. A scoreboard class keeps its own
// coefficient and channel history state, works out each filtered word, and
// checks the results in order. Both handshakes idle at random, and the
// receiver holds off long enough to back the block up into its input.
// ---------------------------------------------------------------------------

module biquad_df1_multichannel_filter_tb;
  import bqdf1_pkg::*;

  class biquad_scoreboard;
    logic signed [CoefW-1:0]   b0, b1, b2, a1, a2;
    logic signed [SampleW-1:0] x_hist1 [8];
    logic signed [SampleW-1:0] x_hist2 [8];
    logic signed [YW-1:0]      y_hist1 [8];
    logic signed [YW-1:0]      y_hist2 [8];
    logic [WordW-1:0]          due_words [$];
    logic [ChW-1:0]            due_channels [$];
    int unsigned               errors;

    function new();
      b0 = CoefB0Reset;
      b1 = '0;
      b2 = '0;
      a1 = '0;
      a2 = '0;
      foreach (x_hist1[i]) begin
        x_hist1[i] = '0;
        x_hist2[i] = '0;
        y_hist1[i] = '0;
        y_hist2[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_coef(cfg_idx_e idx, logic [CoefW-1:0] value);
      case (idx)
        CFG_B0: b0 = value;
        CFG_B1: b1 = value;
        CFG_B2: b2 = value;
        CFG_A1: a1 = value;
        CFG_A2: a2 = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    // Sums exactly at Q.52, with the feedback products floored from Q.61,
    // then floors to Q.32 and saturates to the 40-bit history range.
    function void note_sample(logic [WordW-1:0] word, logic [ChW-1:0] ch);
      logic signed [79:0] x, acc, y;
      longint             y_val, q;
      x = $signed(word[31:8]);
      acc = b0 * x + b1 * x_hist1[ch] + b2 * x_hist2[ch];
      acc = acc - ((a1 * y_hist1[ch]) >>> 9) - ((a2 * y_hist2[ch]) >>> 9);
      y = acc >>> 20;
      if (y > YMax) begin
        y = YMax;
      end else if (y < YMin) begin
        y = YMin;
      end
      x_hist2[ch] = x_hist1[ch];
      x_hist1[ch] = x[SampleW-1:0];
      y_hist2[ch] = y_hist1[ch];
      y_hist1[ch] = y[YW-1:0];
      y_val = longint'(y);
      if (y_val >= 0) begin
        q = (y_val + 256) / 512;
      end else begin
        q = -((-y_val + 256) / 512);
      end
      due_words.push_back({q[23:0], 8'h00});
      due_channels.push_back(ch);
    endfunction

    function void check_result(logic [WordW-1:0] word, logic [ChW-1:0] ch);
      logic [WordW-1:0] want_word;
      logic [ChW-1:0]   want_ch;
      if (due_words.size() == 0) begin
        $error("out_word: expected nothing, actual %h (out_channel %0d)", word, ch);
        errors++;
        return;
      end
      want_word = due_words.pop_front();
      want_ch   = due_channels.pop_front();
      if (word !== want_word) begin
        $error("out_word: expected %h, actual %h", want_word, word);
        errors++;
      end
      if (ch !== want_ch) begin
        $error("out_channel: expected %0d, actual %0d", want_ch, ch);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_idx_i;
  logic [CoefW-1:0]          cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [WordW-1:0]   sample_word_i;
  logic [ChW-1:0]            channel_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [WordW-1:0]   out_word_o;
  logic [ChW-1:0]            out_channel_o;

  biquad_scoreboard sb;
  bit               steady_flow = 1'b0;

  biquad_df1_multichannel_filter #(
    .NUM_CHANNELS(8)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_word_i(sample_word_i),
    .channel_i    (channel_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o),
    .out_channel_o(out_channel_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [WordW-1:0] random_word();
    int r, level;
    r = $urandom_range(0, 99);
    level = int'($urandom_range(0, 131071)) - 65536;
    if (r < 60) return $urandom();
    if (r < 85) return {level[23:0], 8'($urandom())};
    return {($urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000), 8'($urandom())};
  endfunction

  function automatic logic [CoefW-1:0] extreme_coef();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_sample(logic [WordW-1:0] word, logic [ChW-1:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_word_i <= word;
    channel_i     <= ch;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    sb.note_sample(word, ch);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CoefW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_coef(idx, value);
  endtask

  task automatic program_coefs(logic [CoefW-1:0] b0, logic [CoefW-1:0] b1,
                               logic [CoefW-1:0] b2, logic [CoefW-1:0] a1,
                               logic [CoefW-1:0] a2);
    write_reg(CFG_B0, b0);
    write_reg(CFG_B1, b1);
    write_reg(CFG_B2, b2);
    write_reg(CFG_A1, a1);
    write_reg(CFG_A2, a2);
    cfg_we_i <= 1'b0;
  endtask

  // The receiver stalls at random and, twice in the run, holds off for a
  // long stretch so that the block fills and refuses further words.
  initial begin : receiver
    int stall_left;
    int results_seen;
    int r;
    stall_left   = 0;
    results_seen = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_word_o, out_channel_o);
        results_seen++;
        if (results_seen == 120 || results_seen == 400) stall_left = 150;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (steady_flow) begin
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready_i <= 1'b1;
        end else if (r < 92) begin
          out_ready_i <= 1'b0;
          stall_left = $urandom_range(0, 3);
        end else begin
          out_ready_i <= 1'b0;
          stall_left = $urandom_range(8, 40);
        end
      end
    end
  end

  initial begin : stimulus
    logic [CoefW-1:0] c [5];
    logic [ChW-1:0]   ch;
    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_B0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    sample_word_i <= '0;
    channel_i     <= '0;
    ch = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Unity gain from the reset coefficients: field extremes and ignored low bits.
    send_sample(32'h7FFF_FF00, 3'd0);
    send_sample(32'h8000_0000, 3'd1);
    send_sample(32'h0000_00FF, 3'd2);
    send_sample(32'hFFFF_FF00, 3'd3);
    send_sample(32'h0000_0100, 3'd4);
    send_sample(32'h7FFF_FFFF, 3'd5);
    send_sample(32'h8000_00FF, 3'd6);
    send_sample(32'h0000_0000, 3'd7);
    send_sample(32'h1234_5678, 3'd0);
    send_sample(32'hA5A5_A5A5, 3'd0);
    wait_idle();

    // Half gain puts odd samples exactly on a rounding tie in both signs.
    program_coefs(32'h1000_0000, '0, '0, '0, '0);
    send_sample(32'h0000_0100, 3'd2);
    send_sample(32'hFFFF_FF00, 3'd3);
    send_sample(32'h0000_0300, 3'd4);
    send_sample(32'hFFFF_FD00, 3'd5);
    wait_idle();

    // Register extremes: the feedback grows until the history saturates.
    program_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
    repeat (5) send_sample(32'h7FFF_FF00, 3'd1);
    wait_idle();
    program_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000);
    repeat (4) send_sample(32'h8000_0000, 3'd2);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      steady_flow = (p == 2 || p == 5);
      case (p % 4)
        0: begin
          c[0] = $urandom_range(0, 32'h0400_0000);
          c[1] = c[0] << 1;
          c[2] = c[0];
          c[3] = -$urandom_range(32'h2000_0000, 32'h2800_0000);
          c[4] = $urandom_range(32'h0999_999A, 32'h1999_9999);
        end
        1: begin
          foreach (c[i]) c[i] = $urandom();
        end
        2: begin
          foreach (c[i]) c[i] = extreme_coef();
        end
        default: begin
          foreach (c[i]) c[i] = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        end
      endcase
      program_coefs(c[0], c[1], c[2], c[3], c[4]);
      repeat (66) begin
        if ($urandom_range(0, 9) >= 3) ch = 3'($urandom_range(0, 7));
        send_sample(random_word(), ch);
      end
      wait_idle();
    end
    steady_flow = 1'b0;
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("biquad_df1_multichannel_filter: match");
    end else begin
      $display("biquad_df1_multichannel_filter: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("biquad_df1_multichannel_filter: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bqdf1_pkg.sv
rtl/bqdf1_ram.sv
rtl/bqdf1_hist.sv
rtl/bqdf1_core.sv
rtl/biquad_df1_multichannel_filter.sv
tb/biquad_df1_multichannel_filter_tb.sv
